// ----- design/fct_pkg.sv -----
// ----------------------------------------------------------------------------
// fct_pkg
// shared types and constants of the flow completion tracker
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int FLOW_ID_W  = 64;
    localparam int COUNT_W    = 32;
    localparam int SIZE_W     = 32;
    localparam int PAYLOAD_W  = 16;
    localparam int TIME_W     = 63;
    localparam int BYTES_W    = 48;
    localparam int STATUS_W   = 2;

    // status codes of a result item
    localparam logic [STATUS_W-1:0] STATUS_UPDATED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    // hash unit folds this many key bits per cycle
    localparam int HASH_BITS   = 4;
    localparam int HASH_CHUNKS = FLOW_ID_W / HASH_BITS;
    localparam int HASH_CNT_W  = $clog2(HASH_CHUNKS + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_WRITE
    } t_state;

    // one table slot
    typedef struct packed {
        logic                 used;
        logic [FLOW_ID_W-1:0] key;
        logic [TIME_W-1:0]    first_time;
        logic [TIME_W-1:0]    last_time;
        logic [COUNT_W-1:0]   expected;
        logic [COUNT_W-1:0]   count;
        logic [SIZE_W-1:0]    size;
        logic [BYTES_W-1:0]   bytes;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch the input item, start hashing
        logic hash_step;   // fold one chunk of the key
        logic clr_step;    // zero one slot of the clearing sweep
        logic probe_init;  // first probe at the home slot
        logic rd_en;       // read the slot at the probe address
        logic probe_next;  // move to the next slot
        logic set_full;    // no slot found
        logic commit;      // write back the slot and load the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hash_done;
        logic clr_last;
        logic match;       // slot is free or holds the flow
        logic probe_last;
        logic out_busy;    // result register still held by the receiver
    } t_sts;

endpackage

// ----- design/fct_ctrl.sv -----
// ----------------------------------------------------------------------------
// fct_ctrl
// sequencer for the clearing sweep, hashing, probing and write-back
// ----------------------------------------------------------------------------
module fct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fct_pkg::t_sts i_sts,
    output fct_pkg::t_cmd o_cmd
);
    import fct_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_HASH;
            end
            ST_HASH: begin
                if (i_sts.hash_done) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.match || i_sts.probe_last) n_state = ST_WRITE;
                else n_state = ST_READ;
            end
            ST_WRITE: begin
                if (!i_sts.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_HASH: begin
                o_cmd.hash_step  = !i_sts.hash_done;
                o_cmd.probe_init = i_sts.hash_done;
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_CHECK: begin
                o_cmd.set_full   = !i_sts.match && i_sts.probe_last;
                o_cmd.probe_next = !i_sts.match && !i_sts.probe_last;
            end
            ST_WRITE: begin
                o_cmd.commit = !i_sts.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/fct_dp.sv -----
// ----------------------------------------------------------------------------
// fct_dp
// flow table memory, home slot hash, probe address and result registers
// ----------------------------------------------------------------------------
module fct_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fct_pkg::t_cmd                    i_cmd,
    output fct_pkg::t_sts                    o_sts,
    input  logic [fct_pkg::FLOW_ID_W-1:0]    i_flow_id,
    input  logic [fct_pkg::COUNT_W-1:0]      i_expected_packets,
    input  logic [fct_pkg::SIZE_W-1:0]       i_flow_bytes,
    input  logic [fct_pkg::PAYLOAD_W-1:0]    i_payload_length,
    input  logic [fct_pkg::TIME_W-1:0]       i_arrival_time,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [fct_pkg::STATUS_W-1:0]     o_status,
    output logic [fct_pkg::FLOW_ID_W-1:0]    o_done_flow_id,
    output logic [fct_pkg::SIZE_W-1:0]       o_done_flow_bytes,
    output logic [fct_pkg::COUNT_W-1:0]      o_done_expected,
    output logic [fct_pkg::COUNT_W-1:0]      o_done_received,
    output logic [fct_pkg::BYTES_W-1:0]      o_received_bytes_total,
    output logic [fct_pkg::TIME_W-1:0]       o_start_time,
    output logic [fct_pkg::TIME_W-1:0]       o_end_time,
    output logic [fct_pkg::TIME_W-1:0]       o_completion_time
);
    import fct_pkg::*;

    localparam int  IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam bit  IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(TABLE_DEPTH);

    // captured item
    logic [FLOW_ID_W-1:0] r_flow_id;
    logic [COUNT_W-1:0]   r_expected;
    logic [SIZE_W-1:0]    r_size;
    logic [PAYLOAD_W-1:0] r_payload;
    logic [TIME_W-1:0]    r_now;

    // home slot remainder, key folded from the top a chunk per cycle
    logic [FLOW_ID_W-1:0]  r_hash_sr;
    logic [IDX_W-1:0]      r_rem;
    logic [IDX_W-1:0]      n_rem;
    logic [HASH_CNT_W-1:0] r_hcnt;

    // probe
    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] r_probe;
    logic             r_full;

    // table
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;
    logic   mem_we;
    t_entry mem_wd;

    // update of the slot
    logic                 first_pkt;
    logic [COUNT_W-1:0]   upd_expected;
    logic [COUNT_W-1:0]   upd_count;
    logic [SIZE_W-1:0]    upd_size;
    logic [TIME_W-1:0]    upd_first;
    logic [BYTES_W:0]     bytes_sum;
    logic [BYTES_W-1:0]   upd_bytes;
    logic                 flow_done;
    t_entry               upd_entry;

    // result register
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_status;
    logic [FLOW_ID_W-1:0] r_o_flow_id;
    logic [SIZE_W-1:0]    r_o_size;
    logic [COUNT_W-1:0]   r_o_expected;
    logic [COUNT_W-1:0]   r_o_received;
    logic [BYTES_W-1:0]   r_o_bytes;
    logic [TIME_W-1:0]    r_o_start;
    logic [TIME_W-1:0]    r_o_end;
    logic [TIME_W-1:0]    r_o_compl;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_flow_id  <= i_flow_id;
            r_expected <= i_expected_packets;
            r_size     <= i_flow_bytes;
            r_payload  <= i_payload_length;
            r_now      <= i_arrival_time;
        end
    end

    // restoring remainder, HASH_BITS steps of compare and subtract
    always_comb begin
        logic [IDX_W:0] t;
        t = {1'b0, r_rem};
        for (int b = 0; b < HASH_BITS; b++) begin
            t = {t[IDX_W-1:0], r_hash_sr[FLOW_ID_W-1-b]};
            if (t >= DEPTH_X) t = t - DEPTH_X;
        end
        n_rem = t[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt <= '0;
        end else if (i_cmd.capture) begin
            r_hcnt <= '0;
        end else if (i_cmd.hash_step) begin
            r_hcnt <= r_hcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hash_sr <= i_flow_id;
            r_rem     <= IS_POW2 ? i_flow_id[IDX_W-1:0] : '0;
        end else if (i_cmd.hash_step) begin
            r_hash_sr <= r_hash_sr << HASH_BITS;
            r_rem     <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_probe <= '0;
            r_full  <= 1'b0;
        end else begin
            if (i_cmd.capture) r_full <= 1'b0;
            if (i_cmd.set_full) r_full <= 1'b1;
            if (i_cmd.probe_init) begin
                r_addr  <= r_rem;
                r_probe <= '0;
            end else if (i_cmd.probe_next || i_cmd.clr_step) begin
                r_addr  <= (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
                r_probe <= r_probe + 1'b1;
            end
        end
    end

    // slot update
    always_comb begin
        first_pkt    = (r_rd.count == '0);
        upd_expected = first_pkt ? r_expected : r_rd.expected;
        upd_size     = first_pkt ? r_size     : r_rd.size;
        upd_first    = first_pkt ? r_now      : r_rd.first_time;
        upd_count    = r_rd.count + 1'b1;
        bytes_sum    = {1'b0, r_rd.bytes} + (BYTES_W + 1)'(r_payload);
        upd_bytes    = bytes_sum[BYTES_W] ? {BYTES_W{1'b1}} : bytes_sum[BYTES_W-1:0];
        flow_done    = (upd_count == upd_expected);

        upd_entry.used       = 1'b1;
        upd_entry.key        = r_flow_id;
        upd_entry.first_time = upd_first;
        upd_entry.last_time  = r_now;
        upd_entry.expected   = upd_expected;
        upd_entry.count      = upd_count;
        upd_entry.size       = upd_size;
        upd_entry.bytes      = upd_bytes;

        mem_we = i_cmd.clr_step || (i_cmd.commit && !r_full);
        mem_wd = (i_cmd.clr_step || flow_done) ? '0 : upd_entry;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_addr] <= mem_wd;
        if (i_cmd.rd_en) r_rd <= r_mem[r_addr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_flow_id  <= '0;
            r_o_size     <= '0;
            r_o_expected <= '0;
            r_o_received <= '0;
            r_o_bytes    <= '0;
            r_o_start    <= '0;
            r_o_end      <= '0;
            r_o_compl    <= '0;
            if (r_full) begin
                r_status <= STATUS_FULL;
            end else if (flow_done) begin
                r_status     <= STATUS_DONE;
                r_o_flow_id  <= r_flow_id;
                r_o_size     <= upd_size;
                r_o_expected <= upd_expected;
                r_o_received <= upd_count;
                r_o_bytes    <= upd_bytes;
                r_o_start    <= upd_first;
                r_o_end      <= r_now;
                r_o_compl    <= r_now - upd_first;
            end else begin
                r_status <= STATUS_UPDATED;
            end
        end
    end

    always_comb begin
        o_sts.hash_done  = IS_POW2 || (r_hcnt == HASH_CNT_W'(HASH_CHUNKS));
        o_sts.clr_last   = (r_addr == LAST_IDX);
        o_sts.match      = !r_rd.used || (r_rd.key == r_flow_id);
        o_sts.probe_last = (r_probe == LAST_IDX);
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid            = r_out_valid;
    assign o_status               = r_status;
    assign o_done_flow_id         = r_o_flow_id;
    assign o_done_flow_bytes      = r_o_size;
    assign o_done_expected        = r_o_expected;
    assign o_done_received        = r_o_received;
    assign o_received_bytes_total = r_o_bytes;
    assign o_start_time           = r_o_start;
    assign o_end_time             = r_o_end;
    assign o_completion_time      = r_o_compl;

endmodule

// ----- design/flow_completion_tracker.sv -----
// ----------------------------------------------------------------------------
// flow_completion_tracker
// per-flow packet and byte tracker over a linear probing flow table
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready) takes one packet item: flow id,
//   expected packet count, flow size, payload length and arrival time
//   output channel (o_out_valid / i_out_ready) gives exactly one result item
//   per packet: updated, flow done with its record, or table full
//   steps per item: take it, hash its home slot (four key bits a cycle
//   unless TABLE_DEPTH is a power of two), memory read then compare for
//   each probed slot, and write-back; the next item is taken only after
//   write-back, so the probe chain length sets the rate
//   reset runs a clearing pass over every table slot, during which no
//   item is taken
//   the result sits in an output register; a new item is taken and worked on
//   while the receiver stalls, and the block waits before write-back only
//   when the previous result has still not been taken
// ----------------------------------------------------------------------------
module flow_completion_tracker #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [fct_pkg::FLOW_ID_W-1:0]    i_flow_id,
    input  logic [fct_pkg::COUNT_W-1:0]      i_expected_packets,
    input  logic [fct_pkg::SIZE_W-1:0]       i_flow_bytes,
    input  logic [fct_pkg::PAYLOAD_W-1:0]    i_payload_length,
    input  logic [fct_pkg::TIME_W-1:0]       i_arrival_time,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [fct_pkg::STATUS_W-1:0]     o_status,
    output logic [fct_pkg::FLOW_ID_W-1:0]    o_done_flow_id,
    output logic [fct_pkg::SIZE_W-1:0]       o_done_flow_bytes,
    output logic [fct_pkg::COUNT_W-1:0]      o_done_expected,
    output logic [fct_pkg::COUNT_W-1:0]      o_done_received,
    output logic [fct_pkg::BYTES_W-1:0]      o_received_bytes_total,
    output logic [fct_pkg::TIME_W-1:0]       o_start_time,
    output logic [fct_pkg::TIME_W-1:0]       o_end_time,
    output logic [fct_pkg::TIME_W-1:0]       o_completion_time
);
    import fct_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: clear sweep, hash, probe loop, write-back
    fct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // table memory, hash unit, slot update and result register
    fct_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_sts                  (sts),
        .i_flow_id              (i_flow_id),
        .i_expected_packets     (i_expected_packets),
        .i_flow_bytes           (i_flow_bytes),
        .i_payload_length       (i_payload_length),
        .i_arrival_time         (i_arrival_time),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_status               (o_status),
        .o_done_flow_id         (o_done_flow_id),
        .o_done_flow_bytes      (o_done_flow_bytes),
        .o_done_expected        (o_done_expected),
        .o_done_received        (o_done_received),
        .o_received_bytes_total (o_received_bytes_total),
        .o_start_time           (o_start_time),
        .o_end_time             (o_end_time),
        .o_completion_time      (o_completion_time)
    );

endmodule
